// ===== hw/rtl/sobel_edge_magnitude_core_defines.svh =====
// Assertion macros used by the core's top-level RTL file.
// Define NO_ASSERTIONS to compile them out.
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// ante holds -> cons holds in the same cycle
`define SEM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SEM_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/sem_pkg.sv =====
`default_nettype none

package sem_pkg;

  // Fixed field widths
  localparam int ChanW        = 8;
  localparam int FrameWidthW  = 11;
  localparam int FrameHeightW = 13;
  localparam int CfgIndexW    = 2;
  localparam int CfgDataW     = 13;
  localparam int GradW        = 11;   // |gx|, |gy| <= 1020
  localparam int SqW          = 22;   // gx^2 + gy^2 <= 2^21
  localparam int QuotW        = 13;   // row index < 8191
  localparam int TapW         = 4;
  localparam int RootNumW     = 16;
  localparam int RootW        = 17;

  typedef struct packed {
    logic             command;
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
  } item_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             frame_last;
  } result_t;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [CfgIndexW-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [FrameWidthW-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [FrameHeightW-1:0] FRAME_HEIGHT_RESET = 13'd1;

  // Above this sum of squares the rounded root is 256 or more
  localparam logic [SqW-1:0]   SAT_LIMIT = 22'd65280;
  localparam logic [ChanW-1:0] SAT_MAX   = 8'd255;

  localparam logic [TapW-1:0] TAP_LAST  = 4'd8;
  localparam logic [3:0]      DIV_LAST  = 4'd12;
  localparam logic [2:0]      ROOT_LAST = 3'd7;
  localparam logic [RootNumW-1:0] ROOT_PROBE_INIT = 16'h4000;

  typedef enum logic [2:0] {
    TOP_IDLE,
    TOP_DIV,
    TOP_READ,
    TOP_DRAIN,
    TOP_START,
    TOP_MAG,
    TOP_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    MAG_IDLE,
    MAG_SQX,
    MAG_SQY,
    MAG_CHECK,
    MAG_ROOT,
    MAG_ROUND,
    MAG_DONE
  } mag_state_t;

  // Window row / column of a tap, 0..2, raster order
  function automatic logic [1:0] tap_row(input logic [TapW-1:0] tap);
    logic [1:0] r;
    case (tap)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_col(input logic [TapW-1:0] tap);
    logic [1:0] c;
    case (tap)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic signed [2:0] kern_x(input logic [TapW-1:0] tap);
    logic signed [2:0] k;
    case (tap)
      4'd0, 4'd6: k = -3'sd1;
      4'd2, 4'd8: k = 3'sd1;
      4'd3:       k = -3'sd2;
      4'd5:       k = 3'sd2;
      default:    k = 3'sd0;
    endcase
    return k;
  endfunction

  function automatic logic signed [2:0] kern_y(input logic [TapW-1:0] tap);
    logic signed [2:0] k;
    case (tap)
      4'd0, 4'd2: k = -3'sd1;
      4'd1:       k = -3'sd2;
      4'd6, 4'd8: k = 3'sd1;
      4'd7:       k = 3'sd2;
      default:    k = 3'sd0;
    endcase
    return k;
  endfunction

  // v * k for k in -2..2, shifts only
  function automatic logic signed [GradW-1:0] weigh(input logic [ChanW-1:0] v,
                                                    input logic signed [2:0] k);
    logic signed [GradW-1:0] e;
    logic signed [GradW-1:0] w;
    e = signed'(GradW'(v));
    case (k)
      -3'sd2:  w = -(e <<< 1);
      -3'sd1:  w = -e;
      3'sd1:   w = e;
      3'sd2:   w = e <<< 1;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sobel_edge_magnitude_core.sv =====
// A pixel's result is worked out once the item W+1 stream positions later is taken;
//   result_valid then goes high and the result waits in the output register.
// An item that produces a result holds off further items until its result is loaded (13-step
//   divider, nine reads of the single-read-port line store, 8-step square root);
//   an item with no result stalls nothing; a config write stalls items the cycle after it.
// Reset (rst, synchronous, high): control cleared, frame_width 1024, frame_height 1, items
//   held off in the first cycle after reset; the line store is not initialized, needs no clearing.
`default_nettype none

`include "sobel_edge_magnitude_core_defines.svh"

module sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // pixel / flush transactions
  input  logic                              item_valid,
  output logic                              item_stall,
  input  sem_pkg::item_t                    item,
  // result transactions
  output logic                              result_valid,
  input  logic                              result_stall,
  output sem_pkg::result_t                  result,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sem_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [sem_pkg::CfgDataW-1:0]      cfg_data
);

  // Ring of the last 2*MAX_WIDTH+3 stream items: every neighbor of the centre
  // pixel (positions p-W-1 .. p+W+1) is still there when its result is due.
  localparam int RingDepth = 2 * MAX_WIDTH + 3;
  localparam int AW        = $clog2(RingDepth);
  localparam int AW1       = AW + 1;
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int ColW      = WW + 1;
  localparam int PosW      = WW + sem_pkg::FrameHeightW;
  localparam int RowW      = sem_pkg::QuotW + 1;
  localparam int PixW      = 3 * sem_pkg::ChanW;

  // ---------------------------------------------------------------------------
  // Configuration registers and derived frame geometry
  // ---------------------------------------------------------------------------
  logic [sem_pkg::FrameWidthW-1:0]  frame_width;
  logic [sem_pkg::FrameHeightW-1:0] frame_height;
  logic                             cfg_settle;   // geometry registers catching up
  logic                             cfg_fire;

  logic [WW-1:0]                    w_clamp;
  logic [sem_pkg::FrameHeightW-1:0] h_clamp;
  logic [WW-1:0]                    w_eff;
  logic [sem_pkg::FrameHeightW-1:0] h_eff;
  logic [PosW-1:0]                  pixels;       // W*H
  logic [PosW-1:0]                  last_pos;     // W*H + W, last stream position

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sem_pkg::FRAME_WIDTH_RESET;
      frame_height <= sem_pkg::FRAME_HEIGHT_RESET;
      cfg_settle   <= 1'b1;   // geometry picks up the reset values next cycle
    end else begin
      cfg_settle <= cfg_fire;
      if (cfg_fire) begin
        case (cfg_index)
          sem_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[sem_pkg::FrameWidthW-1:0];
          sem_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: begin
            // index beyond the register list: ignored
          end
        endcase
      end
    end
  end

  // W = clamp(frame_width, 1, MAX_WIDTH), H = max(frame_height, 1)
  always_comb begin
    if (frame_width == '0) begin
      w_clamp = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(frame_width);
    end
    h_clamp = (frame_height == '0) ? sem_pkg::FrameHeightW'(1) : frame_height;
  end

  // Retimed every cycle; cfg_settle blocks items for the cycle they lag.
  always_ff @(posedge clk) begin
    w_eff    <= w_clamp;
    h_eff    <= h_clamp;
    pixels   <= PosW'(w_clamp) * PosW'(h_clamp);
    last_pos <= PosW'(w_clamp) * (PosW'(h_clamp) + PosW'(1));
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  sem_pkg::top_state_t state, state_next;

  logic            item_fire;
  logic            load;
  logic            mag_start;
  logic [2:0]      mag_done;
  logic [3:0]      div_cnt;
  logic [sem_pkg::TapW-1:0] tap;

  logic [PosW-1:0] pos;        // stream position of the next item
  logic [AW-1:0]   slot;       // pos mod RingDepth
  logic            has_result;
  logic [PosW-1:0] p_now;      // centre pixel whose window completes now
  logic [PixW-1:0] pix;

  assign item_fire = item_valid && !item_stall;

  // An item at stream position s finishes the window of pixel s-W-1
  assign p_now      = pos - PosW'(w_eff) - PosW'(1);
  assign has_result = (pos > PosW'(w_eff)) && (p_now < pixels);

  // Flush items and anything past the last pixel store black
  assign pix = (item.command == sem_pkg::CMD_PIXEL && pos < pixels)
             ? {item.in_red, item.in_green, item.in_blue} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sem_pkg::TOP_IDLE;
      pos   <= '0;
      slot  <= '0;
    end else begin
      state <= state_next;
      if (item_fire) begin
        if (pos >= last_pos) begin
          pos  <= '0;
          slot <= '0;
        end else begin
          pos  <= pos + PosW'(1);
          slot <= (slot == AW'(RingDepth - 1)) ? '0 : slot + AW'(1);
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    mag_start  = 1'b0;
    load       = 1'b0;
    case (state)
      sem_pkg::TOP_IDLE: begin
        item_stall = cfg_settle;
        if (item_fire && has_result) begin
          state_next = sem_pkg::TOP_DIV;
        end
      end
      sem_pkg::TOP_DIV: begin
        if (div_cnt == sem_pkg::DIV_LAST) begin
          state_next = sem_pkg::TOP_READ;
        end
      end
      sem_pkg::TOP_READ: begin
        if (tap == sem_pkg::TAP_LAST) begin
          state_next = sem_pkg::TOP_DRAIN;
        end
      end
      sem_pkg::TOP_DRAIN: state_next = sem_pkg::TOP_START;
      sem_pkg::TOP_START: begin
        mag_start  = 1'b1;
        state_next = sem_pkg::TOP_MAG;
      end
      sem_pkg::TOP_MAG: begin
        if (&mag_done) begin
          state_next = sem_pkg::TOP_OUT;
        end
      end
      sem_pkg::TOP_OUT: begin
        // output register free, or its transaction completes this edge
        if (!result_valid || !result_stall) begin
          load       = 1'b1;
          state_next = sem_pkg::TOP_IDLE;
        end
      end
      default: state_next = sem_pkg::TOP_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Row / column of the centre pixel: restoring divide p / W, one quotient bit
  // per cycle (p < W*8191, so 13 bits suffice)
  // ---------------------------------------------------------------------------
  logic [PosW-1:0]              div_rem;
  logic [PosW-1:0]              dsr;      // W << (12 - div_cnt)
  logic [WW-1:0]                div_w;
  logic [sem_pkg::QuotW-1:0]    quot;
  logic                         div_ge;
  logic [AW-1:0]                base;     // ring slot of the item just written
  logic                         frame_last_q;

  assign div_ge = (div_rem >= dsr);

  always_ff @(posedge clk) begin
    if (item_fire) begin
      base         <= slot;
      div_rem      <= p_now;
      dsr          <= PosW'(w_eff) << sem_pkg::DIV_LAST;
      div_w        <= w_eff;
      quot         <= '0;
      div_cnt      <= '0;
      frame_last_q <= (p_now == pixels - PosW'(1));
    end else if (state == sem_pkg::TOP_DIV) begin
      if (div_ge) begin
        div_rem <= div_rem - dsr;
      end
      quot    <= {quot[sem_pkg::QuotW-2:0], div_ge};
      dsr     <= dsr >> 1;
      div_cnt <= div_cnt + 4'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // Neighborhood reads: one tap per cycle, ring index = base - offset
  // ---------------------------------------------------------------------------
  logic [WW-1:0]   pcol;
  logic [1:0]      trow;
  logic [1:0]      tcol;
  logic            row_ok;
  logic            col_ok;
  logic            tap_in;
  logic [AW1-1:0]  row_off;
  logic [AW1-1:0]  off;
  logic [AW1-1:0]  diff;
  logic [AW-1:0]   rd_addr;
  logic [PixW-1:0] rd_data;

  assign pcol = div_rem[WW-1:0];
  assign trow = sem_pkg::tap_row(tap);
  assign tcol = sem_pkg::tap_col(tap);

  always_comb begin
    case (trow)
      2'd0:    row_ok = (quot != '0);
      2'd2:    row_ok = (RowW'(quot) + RowW'(1)) < RowW'(h_eff);
      default: row_ok = 1'b1;
    endcase
    case (tcol)
      2'd0:    col_ok = (pcol != '0);
      2'd2:    col_ok = (ColW'(pcol) + ColW'(1)) < ColW'(w_eff);
      default: col_ok = 1'b1;
    endcase
    tap_in = row_ok && col_ok;

    // offset back from the newest item: (2-row)*W + (2-col)
    case (trow)
      2'd0:    row_off = AW1'(w_eff) << 1;
      2'd1:    row_off = AW1'(w_eff);
      default: row_off = '0;
    endcase
    off  = row_off + AW1'(2'd2 - tcol);
    diff = AW1'(base) - off;
    rd_addr = diff[AW] ? diff[AW-1:0] + AW'(RingDepth) : diff[AW-1:0];
  end

  sem_ram #(
    .WIDTH(PixW),
    .DEPTH(RingDepth)
  ) u_line_store (
    .clk  (clk),
    .we   (item_fire),
    .waddr(slot),
    .wdata(pix),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // The write happens on the accepting edge; reads start only after the divide,
  // so the FSM itself keeps write and reads of the same entry apart.

  logic                          acc_en;
  logic                          acc_in;
  logic [sem_pkg::TapW-1:0]      acc_tap;
  logic [sem_pkg::ChanW-1:0]     rd_chan [3];
  logic signed [sem_pkg::GradW-1:0] gx [3];
  logic signed [sem_pkg::GradW-1:0] gy [3];
  logic [sem_pkg::ChanW-1:0]     mag [3];

  assign rd_chan[0] = rd_data[3*sem_pkg::ChanW-1:2*sem_pkg::ChanW];
  assign rd_chan[1] = rd_data[2*sem_pkg::ChanW-1:sem_pkg::ChanW];
  assign rd_chan[2] = rd_data[sem_pkg::ChanW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= (state == sem_pkg::TOP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      tap <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        gx[ch] <= '0;
        gy[ch] <= '0;
      end
    end else begin
      if (state == sem_pkg::TOP_READ) begin
        tap     <= tap + sem_pkg::TapW'(1);
        acc_tap <= tap;
        acc_in  <= tap_in;
      end
      // read data of the previous tap arrives this cycle
      if (acc_en && acc_in) begin
        for (int ch = 0; ch < 3; ch++) begin
          gx[ch] <= gx[ch] + sem_pkg::weigh(rd_chan[ch], sem_pkg::kern_x(acc_tap));
          gy[ch] <= gy[ch] + sem_pkg::weigh(rd_chan[ch], sem_pkg::kern_y(acc_tap));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Magnitude, one unit per channel in lockstep
  // ---------------------------------------------------------------------------
  for (genvar ch = 0; ch < 3; ch++) begin : g_mag
    sem_mag u_mag (
      .clk  (clk),
      .rst  (rst),
      .start(mag_start),
      .gx   (gx[ch]),
      .gy   (gy[ch]),
      .done (mag_done[ch]),
      .mag  (mag[ch])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: decouples the result transaction from the next item
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_red    <= mag[0];
      result.out_green  <= mag[1];
      result.out_blue   <= mag[2];
      result.frame_last <= frame_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SEM_ASSERT_SAME(a_ring_addr, clk, rst, state == sem_pkg::TOP_READ,
                   rd_addr < AW'(RingDepth), "ring read address out of range")
  `SEM_ASSERT_SAME(a_mag_lockstep, clk, rst, |mag_done, &mag_done,
                   "magnitude units out of step")
  `SEM_ASSERT_NEXT(a_cfg_settle, clk, rst, cfg_fire, item_stall,
                   "item taken while geometry settles")
  `SEM_ASSERT_NEXT(a_div_rem, clk, rst,
                   state == sem_pkg::TOP_DIV && div_cnt == sem_pkg::DIV_LAST,
                   div_rem < PosW'(div_w), "column not below width after divide")

endmodule

`default_nettype wire

// ===== hw/rtl/sem_ram.sv =====
`default_nettype none

module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2051
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sem_mag.sv =====
`default_nettype none

// round(sqrt(gx^2 + gy^2)) saturated at 255; fixed latency, bit-pair root.
module sem_mag (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [sem_pkg::GradW-1:0]    gx,
  input  logic signed [sem_pkg::GradW-1:0]    gy,
  output logic                                done,
  output logic [sem_pkg::ChanW-1:0]           mag
);

  sem_pkg::mag_state_t state, state_next;

  logic signed [sem_pkg::GradW-1:0] gx_q;
  logic signed [sem_pkg::GradW-1:0] gy_q;
  logic signed [sem_pkg::SqW-1:0]   gx_wide;
  logic signed [sem_pkg::SqW-1:0]   gy_wide;
  logic [sem_pkg::SqW-1:0]          sq;
  logic                             sat;
  logic [sem_pkg::RootNumW-1:0]     num;
  logic [sem_pkg::RootW-1:0]        root;
  logic [sem_pkg::RootNumW-1:0]     probe;
  logic [sem_pkg::RootW-1:0]        trial;
  logic [2:0]                       cnt;
  logic [sem_pkg::ChanW-1:0]        mag_q;

  assign gx_wide = sem_pkg::SqW'(gx_q);
  assign gy_wide = sem_pkg::SqW'(gy_q);
  assign trial   = root + sem_pkg::RootW'(probe);
  assign mag     = mag_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sem_pkg::MAG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      sem_pkg::MAG_IDLE: begin
        if (start) begin
          state_next = sem_pkg::MAG_SQX;
        end
      end
      sem_pkg::MAG_SQX:   state_next = sem_pkg::MAG_SQY;
      sem_pkg::MAG_SQY:   state_next = sem_pkg::MAG_CHECK;
      sem_pkg::MAG_CHECK: state_next = sem_pkg::MAG_ROOT;
      sem_pkg::MAG_ROOT: begin
        if (cnt == sem_pkg::ROOT_LAST) begin
          state_next = sem_pkg::MAG_ROUND;
        end
      end
      sem_pkg::MAG_ROUND: state_next = sem_pkg::MAG_DONE;
      sem_pkg::MAG_DONE: begin
        done       = 1'b1;
        state_next = sem_pkg::MAG_IDLE;
      end
      default: state_next = sem_pkg::MAG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      sem_pkg::MAG_IDLE: begin
        if (start) begin
          gx_q <= gx;
          gy_q <= gy;
        end
      end
      sem_pkg::MAG_SQX: begin
        sq <= unsigned'(gx_wide * gx_wide);
      end
      sem_pkg::MAG_SQY: begin
        sq <= sq + unsigned'(gy_wide * gy_wide);
      end
      sem_pkg::MAG_CHECK: begin
        sat   <= (sq > sem_pkg::SAT_LIMIT);
        num   <= sq[sem_pkg::RootNumW-1:0];
        root  <= '0;
        probe <= sem_pkg::ROOT_PROBE_INIT;
        cnt   <= '0;
      end
      sem_pkg::MAG_ROOT: begin
        if (sem_pkg::RootW'(num) >= trial) begin
          num  <= num - trial[sem_pkg::RootNumW-1:0];
          root <= (root >> 1) + sem_pkg::RootW'(probe);
        end else begin
          root <= root >> 1;
        end
        probe <= probe >> 2;
        cnt   <= cnt + 3'd1;
      end
      sem_pkg::MAG_ROUND: begin
        // num now holds sq - root^2
        if (sat) begin
          mag_q <= sem_pkg::SAT_MAX;
        end else if (sem_pkg::RootW'(num) > root) begin
          mag_q <= sem_pkg::ChanW'(root + sem_pkg::RootW'(1));
        end else begin
          mag_q <= sem_pkg::ChanW'(root);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
